[src/sbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WID_W   = COL_W + 1;
  localparam int HGT_W   = ROW_W + 1;
  localparam int THR_W   = 11;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int GRAD_W  = PIX_W + 3;
  localparam int SQ_W    = 2 * GRAD_W - 2;
  localparam int SUM_W   = SQ_W + 1;
  localparam int THSQ_W  = 2 * THR_W;
  localparam int RAD_W   = 2 * PIX_W;
  localparam int REM_W   = PIX_W + 2;
  localparam int SQRT_STEPS = PIX_W;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [WID_W-1:0] RESET_WIDTH     = WID_W'(640);
  localparam logic [HGT_W-1:0] RESET_HEIGHT    = HGT_W'(480);
  localparam logic [THR_W-1:0] RESET_THRESHOLD = THR_W'(255);

  localparam logic [PIX_W-1:0] EDGE_MAX = '1;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_end;
  } tag_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    tag_t                     tag;
  } qitem_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [PIX_W-1:0] root;
  } sqrt_t;

  // one restoring digit of floor(sqrt): two radicand bits in, one root bit out
  function automatic sqrt_t sqrt_step(input logic [REM_W-1:0] rem,
                                      input logic [PIX_W-1:0] root,
                                      input logic [1:0] pair);
    logic [REM_W+1:0] sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    sqrt_t            res;
    sh    = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff  = sh - trial;
    if (sh >= trial) begin
      res.rem  = diff[REM_W-1:0];
      res.root = {root[PIX_W-2:0], 1'b1};
    end else begin
      res.rem  = sh[REM_W-1:0];
      res.root = {root[PIX_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/sbl_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sbl_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [sbl_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface sbl_edge_if;
  logic                      valid;
  logic                      ready;
  logic [sbl_pkg::PIX_W-1:0] edge_value;
  logic [sbl_pkg::ROW_W-1:0] out_row;
  logic [sbl_pkg::COL_W-1:0] out_col;
  logic                      frame_end;

  modport source (output valid, output edge_value, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink (input valid, input edge_value, input out_row, input out_col,
                input frame_end, output ready);
endinterface

`default_nettype wire

[src/sbl_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  sbl_pixel_if.sink                          pixel,
  input  wire logic [sbl_pkg::WID_W-1:0]     eff_width,
  input  wire logic [sbl_pkg::HGT_W-1:0]     eff_height,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output sbl_pkg::qitem_t                    push_item
);

  logic [sbl_pkg::ROW_W-1:0] row;
  logic [sbl_pkg::COL_W-1:0] col;

  logic [sbl_pkg::COL_W-1:0] c_eff;
  logic [sbl_pkg::ROW_W-1:0] r_eff;
  logic [sbl_pkg::HGT_W-1:0] r_tmp;
  logic [sbl_pkg::WID_W-1:0] c_inc;
  logic [sbl_pkg::HGT_W-1:0] r_inc;
  logic [sbl_pkg::COL_W-1:0] col_next;
  logic [sbl_pkg::ROW_W-1:0] row_next;
  logic                      emit;
  sbl_pkg::tag_t             tag;

  logic                      accept;
  logic                      in_ready;

  logic [sbl_pkg::PIX_W-1:0] upper [sbl_pkg::MAX_WIDTH];
  logic [sbl_pkg::PIX_W-1:0] middle [sbl_pkg::MAX_WIDTH];
  logic [sbl_pkg::PIX_W-1:0] top_rd;
  logic [sbl_pkg::PIX_W-1:0] mid_rd;

  logic                      s1_valid;
  logic                      s1_emit;
  logic [sbl_pkg::PIX_W-1:0] s1_pix;
  logic [sbl_pkg::COL_W-1:0] s1_c;
  sbl_pkg::tag_t             s1_tag;
  logic                      s1_adv;

  logic [sbl_pkg::PIX_W-1:0] win [6];

  logic [sbl_pkg::GRAD_W-2:0] sum_r;
  logic [sbl_pkg::GRAD_W-2:0] sum_l;
  logic [sbl_pkg::GRAD_W-2:0] sum_b;
  logic [sbl_pkg::GRAD_W-2:0] sum_t;

  // effective position of this pixel, and where the next one lands
  always_comb begin
    c_eff = col;
    r_tmp = {1'b0, row};
    if ({1'b0, col} >= eff_width) begin
      c_eff = '0;
      r_tmp = {1'b0, row} + sbl_pkg::HGT_W'(1);
    end
    r_eff = (r_tmp >= eff_height) ? '0 : r_tmp[sbl_pkg::ROW_W-1:0];

    c_inc = {1'b0, c_eff} + sbl_pkg::WID_W'(1);
    r_inc = {1'b0, r_eff} + sbl_pkg::HGT_W'(1);
    if (c_inc >= eff_width) begin
      col_next = '0;
      row_next = (r_inc >= eff_height) ? '0 : r_inc[sbl_pkg::ROW_W-1:0];
    end else begin
      col_next = c_inc[sbl_pkg::COL_W-1:0];
      row_next = r_eff;
    end

    emit          = (r_eff >= sbl_pkg::ROW_W'(2)) && (c_eff >= sbl_pkg::COL_W'(2));
    tag.out_row   = r_eff - sbl_pkg::ROW_W'(2);
    tag.out_col   = c_eff - sbl_pkg::COL_W'(2);
    tag.frame_end = ({1'b0, r_eff} == eff_height - sbl_pkg::HGT_W'(1)) &&
                    ({1'b0, c_eff} == eff_width - sbl_pkg::WID_W'(1));
  end

  assign s1_adv      = s1_valid && (!s1_emit || push_ready);
  assign in_ready    = !s1_valid || s1_adv;
  assign pixel.ready = in_ready;
  assign accept      = pixel.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit;
      s1_pix  <= pixel.pixel_value;
      s1_c    <= c_eff;
      s1_tag  <= tag;
    end
  end

  // line stores: read on request, written back when the window moves on
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd <= upper[c_eff];
    end
    if (s1_adv) begin
      upper[s1_c] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd <= middle[c_eff];
    end
    if (s1_adv) begin
      middle[s1_c] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_rd;
      win[4] <= mid_rd;
      win[5] <= s1_pix;
    end
  end

  always_comb begin
    sum_r = {2'b00, top_rd} + {1'b0, mid_rd, 1'b0} + {2'b00, s1_pix};
    sum_l = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
    sum_b = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, s1_pix};
    sum_t = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, top_rd};
    push_item.gx  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    push_item.gy  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    push_item.tag = s1_tag;
  end

  assign push_valid = s1_valid && s1_emit;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(top_rd) && $stable(mid_rd))
    else $error("stalled window lost its line store data");

endmodule

`default_nettype wire

[src/sbl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire sbl_pkg::qitem_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output sbl_pkg::qitem_t      pop_item
);

  sbl_pkg::qitem_t            mem [sbl_pkg::QDEPTH];
  logic [sbl_pkg::QPTR_W-1:0] wr_ptr;
  logic [sbl_pkg::QPTR_W-1:0] rd_ptr;
  logic [sbl_pkg::QCNT_W-1:0] count;
  logic                       push;
  logic                       pop;

  assign push_ready = (count != sbl_pkg::QCNT_W'(sbl_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sbl_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sbl_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sbl_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sbl_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sbl_pkg::QCNT_W'(sbl_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + sbl_pkg::QCNT_W'(1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - sbl_pkg::QCNT_W'(1))
    else $error("queue count missed a pop");

endmodule

`default_nettype wire

[src/sbl_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [sbl_pkg::THR_W-1:0] edge_threshold,
  input  wire logic                      pop_valid,
  output logic                           pop_ready,
  input  wire sbl_pkg::qitem_t           pop_item,
  sbl_edge_if.source                     edges
);

  localparam int N = sbl_pkg::SQRT_STEPS;

  logic [sbl_pkg::THSQ_W-1:0] thr_sq;
  logic                       en;

  logic signed [sbl_pkg::GRAD_W-1:0]   gx_in;
  logic signed [sbl_pkg::GRAD_W-1:0]   gy_in;
  logic signed [2*sbl_pkg::GRAD_W-1:0] gx_sq;
  logic signed [2*sbl_pkg::GRAD_W-1:0] gy_sq;

  logic                      a_vld;
  logic [sbl_pkg::SQ_W-1:0]  a_sqx;
  logic [sbl_pkg::SQ_W-1:0]  a_sqy;
  sbl_pkg::tag_t             a_tag;

  logic [sbl_pkg::SUM_W-1:0] sum;
  logic                      force_max;

  logic                      b_vld;
  logic [sbl_pkg::RAD_W-1:0] b_v;
  logic                      b_force;
  sbl_pkg::tag_t             b_tag;

  logic                      in_vld   [N];
  logic [sbl_pkg::REM_W-1:0] in_rem   [N];
  logic [sbl_pkg::PIX_W-1:0] in_root  [N];
  logic [sbl_pkg::RAD_W-1:0] in_v     [N];
  logic                      in_force [N];
  sbl_pkg::tag_t             in_tag   [N];
  sbl_pkg::sqrt_t            step     [N];

  logic                      s_vld   [N];
  logic [sbl_pkg::REM_W-1:0] s_rem   [N];
  logic [sbl_pkg::PIX_W-1:0] s_root  [N];
  logic [sbl_pkg::RAD_W-1:0] s_v     [N];
  logic                      s_force [N];
  sbl_pkg::tag_t             s_tag   [N];

  assign en        = !s_vld[N-1] || edges.ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    thr_sq <= edge_threshold * edge_threshold;
  end

  // squares
  assign gx_in = pop_item.gx;
  assign gy_in = pop_item.gy;
  assign gx_sq = gx_in * gx_in;
  assign gy_sq = gy_in * gy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= pop_valid;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sqx   <= gx_sq[sbl_pkg::SQ_W-1:0];
      a_sqy   <= gy_sq[sbl_pkg::SQ_W-1:0];
      a_tag   <= pop_item.tag;
      b_v     <= sum[sbl_pkg::RAD_W-1:0];
      b_force <= force_max;
      b_tag   <= a_tag;
    end
  end

  // threshold and saturation
  always_comb begin
    sum       = {1'b0, a_sqx} + {1'b0, a_sqy};
    force_max = ({1'b0, sum} > thr_sq) ||
                (sum[sbl_pkg::SUM_W-1:sbl_pkg::RAD_W] != '0);
  end

  // square root, one result bit per stage
  always_comb begin
    in_vld[0]   = b_vld;
    in_rem[0]   = '0;
    in_root[0]  = '0;
    in_v[0]     = b_v;
    in_force[0] = b_force;
    in_tag[0]   = b_tag;
    for (int i = 1; i < N; i++) begin
      in_vld[i]   = s_vld[i-1];
      in_rem[i]   = s_rem[i-1];
      in_root[i]  = s_root[i-1];
      in_v[i]     = s_v[i-1];
      in_force[i] = s_force[i-1];
      in_tag[i]   = s_tag[i-1];
    end
    for (int i = 0; i < N; i++) begin
      step[i] = sbl_pkg::sqrt_step(in_rem[i], in_root[i],
                                   in_v[i][sbl_pkg::RAD_W-1:sbl_pkg::RAD_W-2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        s_vld[i] <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < N; i++) begin
        s_vld[i] <= in_vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        s_rem[i]   <= step[i].rem;
        s_root[i]  <= step[i].root;
        s_v[i]     <= {in_v[i][sbl_pkg::RAD_W-3:0], 2'b00};
        s_force[i] <= in_force[i];
        s_tag[i]   <= in_tag[i];
      end
    end
  end

  assign edges.valid      = s_vld[N-1];
  assign edges.edge_value = s_force[N-1] ? sbl_pkg::EDGE_MAX : s_root[N-1];
  assign edges.out_row    = s_tag[N-1].out_row;
  assign edges.out_col    = s_tag[N-1].out_col;
  assign edges.frame_end  = s_tag[N-1].frame_end;

endmodule

`default_nettype wire

[src/sobel_edge_threshold.sv]
// Throughput: one pixel per cycle while the edge output is not stalled, set by the
// single read port of each line store and the one-digit-per-stage square root
// pipeline; only full windows give results.
// Reset (rst, synchronous): counters to zero, width 640, height 480, threshold 255,
// queue and pipelines empty. Line stores are not cleared; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold (
  input  wire logic                       clk,
  input  wire logic                       rst,
  sbl_pixel_if.sink                       pixel,
  sbl_edge_if.source                      edges,
  input  wire logic                       cfg_we,
  input  wire logic [sbl_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [sbl_pkg::CFG_W-1:0]  cfg_data
);

  logic [sbl_pkg::WID_W-1:0] image_width;
  logic [sbl_pkg::HGT_W-1:0] image_height;
  logic [sbl_pkg::THR_W-1:0] edge_threshold;
  logic [sbl_pkg::WID_W-1:0] eff_width;
  logic [sbl_pkg::HGT_W-1:0] eff_height;

  logic            push_valid;
  logic            push_ready;
  sbl_pkg::qitem_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  sbl_pkg::qitem_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= sbl_pkg::RESET_WIDTH;
      image_height   <= sbl_pkg::RESET_HEIGHT;
      edge_threshold <= sbl_pkg::RESET_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        sbl_pkg::CFG_IMAGE_WIDTH:    image_width    <= cfg_data[sbl_pkg::WID_W-1:0];
        sbl_pkg::CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[sbl_pkg::HGT_W-1:0];
        sbl_pkg::CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data[sbl_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < sbl_pkg::WID_W'(sbl_pkg::MIN_DIM)) begin
      eff_width = sbl_pkg::WID_W'(sbl_pkg::MIN_DIM);
    end else if (image_width > sbl_pkg::WID_W'(sbl_pkg::MAX_WIDTH)) begin
      eff_width = sbl_pkg::WID_W'(sbl_pkg::MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    if (image_height < sbl_pkg::HGT_W'(sbl_pkg::MIN_DIM)) begin
      eff_height = sbl_pkg::HGT_W'(sbl_pkg::MIN_DIM);
    end else if (image_height > sbl_pkg::HGT_W'(sbl_pkg::MAX_HEIGHT)) begin
      eff_height = sbl_pkg::HGT_W'(sbl_pkg::MAX_HEIGHT);
    end else begin
      eff_height = image_height;
    end
  end

  sbl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sbl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sbl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .edge_threshold (edge_threshold),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .edges          (edges)
  );

endmodule

`default_nettype wire

[test/sobel_edge_threshold_tb.sv]
`timescale 1ns / 1ps

module sobel_edge_threshold_tb;

  localparam logic [sbl_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PIXELS = 330;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MID_WIDTH = 20;

  typedef enum int {STYLE_NOISE, STYLE_BINARY, STYLE_SMOOTH} pix_style_t;

  typedef struct packed {
    logic [sbl_pkg::PIX_W-1:0] edge_value;
    sbl_pkg::tag_t             tag;
  } edge_result_t;

  class edge_scoreboard;
    logic [sbl_pkg::WID_W-1:0] width_cfg;
    logic [sbl_pkg::HGT_W-1:0] height_cfg;
    logic [sbl_pkg::THR_W-1:0] thresh_cfg;
    bit [sbl_pkg::PIX_W-1:0]   upper_line [sbl_pkg::MAX_WIDTH];
    bit [sbl_pkg::PIX_W-1:0]   middle_line [sbl_pkg::MAX_WIDTH];
    bit [sbl_pkg::PIX_W-1:0]   window [6];
    int unsigned               row_cnt;
    int unsigned               col_cnt;
    edge_result_t              expected_q [$];
    int unsigned               errors;

    function new();
      width_cfg  = sbl_pkg::RESET_WIDTH;
      height_cfg = sbl_pkg::RESET_HEIGHT;
      thresh_cfg = sbl_pkg::RESET_THRESHOLD;
      row_cnt    = 0;
      col_cnt    = 0;
      errors     = 0;
    endfunction

    function void set_reg(input logic [sbl_pkg::CIDX_W-1:0] idx,
                          input logic [sbl_pkg::CFG_W-1:0] data);
      case (idx)
        sbl_pkg::CFG_IMAGE_WIDTH: begin
          width_cfg = data[sbl_pkg::WID_W-1:0];
        end
        sbl_pkg::CFG_IMAGE_HEIGHT: begin
          height_cfg = data[sbl_pkg::HGT_W-1:0];
        end
        sbl_pkg::CFG_EDGE_THRESHOLD: begin
          thresh_cfg = data[sbl_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_cfg < sbl_pkg::MIN_DIM) return sbl_pkg::MIN_DIM;
      if (width_cfg > sbl_pkg::MAX_WIDTH) return sbl_pkg::MAX_WIDTH;
      return width_cfg;
    endfunction

    function int unsigned eff_h();
      if (height_cfg < sbl_pkg::MIN_DIM) return sbl_pkg::MIN_DIM;
      if (height_cfg > sbl_pkg::MAX_HEIGHT) return sbl_pkg::MAX_HEIGHT;
      return height_cfg;
    endfunction

    // pixels until both counters are back at zero
    function int unsigned frame_left();
      int unsigned w, h, r, c;
      w = eff_w();
      h = eff_h();
      r = row_cnt;
      c = col_cnt;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      return (h - r) * w - c;
    endfunction

    function void note_pixel(input logic [sbl_pkg::PIX_W-1:0] pix);
      int unsigned  w, h, r, c, sum, thr2, mag;
      int           gx, gy;
      bit [sbl_pkg::PIX_W-1:0] top, mid;
      edge_result_t res;
      w = eff_w();
      h = eff_h();
      r = row_cnt;
      c = col_cnt;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      top = upper_line[c];
      mid = middle_line[c];
      if (r >= 2 && c >= 2) begin
        gx = (int'(top) + 2 * int'(mid) + int'(pix))
           - (int'(window[0]) + 2 * int'(window[1]) + int'(window[2]));
        gy = (int'(window[2]) + 2 * int'(window[5]) + int'(pix))
           - (int'(window[0]) + 2 * int'(window[3]) + int'(top));
        sum  = gx * gx + gy * gy;
        thr2 = thresh_cfg * thresh_cfg;
        if (sum > thr2 || sum >= 65536) begin
          mag = 255;
        end else begin
          mag = 0;
          while ((mag + 1) * (mag + 1) <= sum) mag++;
        end
        res.edge_value    = mag[sbl_pkg::PIX_W-1:0];
        res.tag.out_row   = sbl_pkg::ROW_W'(r - 2);
        res.tag.out_col   = sbl_pkg::COL_W'(c - 2);
        res.tag.frame_end = (r == h - 1) && (c == w - 1);
        expected_q.push_back(res);
      end
      upper_line[c]  = mid;
      middle_line[c] = pix;
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = pix;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_cnt = r;
      col_cnt = c;
    endfunction

    function void check_edge(input edge_result_t got);
      edge_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected edge result at row %0d col %0d", got.tag.out_row, got.tag.out_col);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.edge_value !== want.edge_value) begin
        $error("edge_value: expected %0d, actual %0d", want.edge_value, got.edge_value);
        errors++;
      end
      if (got.tag.out_row !== want.tag.out_row) begin
        $error("out_row: expected %0d, actual %0d", want.tag.out_row, got.tag.out_row);
        errors++;
      end
      if (got.tag.out_col !== want.tag.out_col) begin
        $error("out_col: expected %0d, actual %0d", want.tag.out_col, got.tag.out_col);
        errors++;
      end
      if (got.tag.frame_end !== want.tag.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.tag.frame_end, got.tag.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [sbl_pkg::CIDX_W-1:0] cfg_index;
  logic [sbl_pkg::CFG_W-1:0]  cfg_data;
  int unsigned                stall_pct = 0;
  logic [sbl_pkg::PIX_W-1:0]  pixel_q [$];
  edge_scoreboard             sb;

  sbl_pixel_if pixel_bus ();
  sbl_edge_if  edge_bus ();

  sobel_edge_threshold u_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_bus),
    .edges     (edge_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    edge_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && edge_bus.valid && edge_bus.ready) begin
      sb.check_edge('{edge_value: edge_bus.edge_value,
                      tag: '{out_row: edge_bus.out_row, out_col: edge_bus.out_col,
                             frame_end: edge_bus.frame_end}});
    end
  end

  task automatic write_reg(input logic [sbl_pkg::CIDX_W-1:0] idx,
                           input logic [sbl_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_pixels(input int unsigned n, input pix_style_t style);
    int level;
    level = $urandom_range(255);
    repeat (n) begin
      case (style)
        STYLE_BINARY: begin
          pixel_q.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        end
        STYLE_SMOOTH: begin
          level += int'($urandom_range(4)) - 2;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          pixel_q.push_back(sbl_pkg::PIX_W'(level));
        end
        default: begin
          pixel_q.push_back(sbl_pkg::PIX_W'($urandom));
        end
      endcase
    end
  endfunction

  // 3x3 frame: dark left and middle columns, right column at the given level
  function automatic void add_ramp(input logic [sbl_pkg::PIX_W-1:0] right);
    repeat (3) begin
      pixel_q.push_back(8'h00);
      pixel_q.push_back(8'h00);
      pixel_q.push_back(right);
    end
  endfunction

  task automatic run_pixels(input int unsigned send_idle, input int unsigned recv_stall);
    stall_pct <= recv_stall;
    while (pixel_q.size() > 0) begin
      if ($urandom_range(99) < send_idle) begin
        pixel_bus.valid <= 1'b0;
        @(posedge clk);
      end else begin
        pixel_bus.valid       <= 1'b1;
        pixel_bus.pixel_value <= pixel_q[0];
        @(posedge clk);
        while (!pixel_bus.ready) @(posedge clk);
        sb.note_pixel(pixel_q.pop_front());
      end
    end
    pixel_bus.valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned w_raw;
    int unsigned w_eff;
    int unsigned h_raw;
    int unsigned t_raw;
    int unsigned send_idle;
    int unsigned recv_stall;
    sb = new();
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = sbl_pkg::CFG_IMAGE_WIDTH;
    cfg_data              = '0;
    pixel_bus.valid       = 1'b0;
    pixel_bus.pixel_value = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: start of the first row
    add_pixels(40, STYLE_NOISE);
    run_pixels(0, 0);

    // narrower rows mid-frame: next request starts row 1, stop inside row 5
    write_reg(sbl_pkg::CFG_IMAGE_WIDTH, sbl_pkg::CFG_W'(MID_WIDTH));
    add_pixels(4 * MID_WIDTH + 10, STYLE_NOISE);
    run_pixels(0, 0);

    // shrink mid-frame: both counters end up past the new geometry
    write_reg(sbl_pkg::CFG_IMAGE_WIDTH, 13'h1803);
    write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, 13'h1800);
    write_reg(CFG_UNUSED, '1);
    add_ramp(8'h00);
    add_ramp(8'h01);
    run_pixels(0, 0);
    write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, 13'd4);
    add_ramp(8'h01);
    run_pixels(80, 0);
    write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, 13'd1443);
    add_ramp(8'hFF);
    run_pixels(0, 80);

    sent = 0;
    for (int ph = 0; sent < RANDOM_PIXELS; ph++) begin
      case ($urandom_range(9))
        0: w_raw = $urandom_range(2);
        1: w_raw = $urandom_range(40, 13);
        default: w_raw = $urandom_range(12, 3);
      endcase
      w_eff = (w_raw < sbl_pkg::MIN_DIM) ? sbl_pkg::MIN_DIM : w_raw;
      // a wider row is only safe once the line stores are refilled from row 0
      if ($urandom_range(1) &&
          (w_eff <= sb.eff_w() || sb.frame_left() == sb.eff_w() * sb.eff_h())) begin
        write_reg(sbl_pkg::CFG_IMAGE_WIDTH, {2'($urandom), sbl_pkg::WID_W'(w_raw)});
      end
      if ($urandom_range(1)) begin
        h_raw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(10, 3);
        write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, sbl_pkg::HGT_W'(h_raw));
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(5))
          0: t_raw = 0;
          1: t_raw = 1442;
          2: t_raw = 1443;
          3: t_raw = $urandom_range(2047);
          default: t_raw = $urandom_range(60);
        endcase
        write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, {2'($urandom), sbl_pkg::THR_W'(t_raw)});
      end
      if ($urandom_range(5) == 0) begin
        write_reg(CFG_UNUSED, sbl_pkg::CFG_W'($urandom));
      end
      n = ($urandom_range(2) == 0) ? sb.frame_left() : $urandom_range(60, 20);
      case (ph % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 80;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 80;
        end
        default: begin
          send_idle  = 28;
          recv_stall = 28;
        end
      endcase
      add_pixels(n, pix_style_t'($urandom_range(2)));
      sent += n;
      run_pixels(send_idle, recv_stall);
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
src/sbl_pkg.sv
src/sbl_ifs.sv
src/sbl_front.sv
src/sbl_queue.sv
src/sbl_back.sv
src/sobel_edge_threshold.sv
test/sobel_edge_threshold_tb.sv
